/* design/jsu_pkg.sv */
// Package for the JSON string unescaper: result kinds, decoder phases, byte codes.
// Also holds the hex digit and UTF-8 encoding functions.
// No dependencies.
package jsu_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESCAPE = 2'd1;
  localparam logic [1:0] PH_HEX    = 2'd2;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_N   = 8'h6e;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0c;
  localparam logic [7:0] CODE_LF  = 8'h0a;
  localparam logic [7:0] CODE_CR  = 8'h0d;
  localparam logic [7:0] CODE_TAB = 8'h09;

  localparam logic [15:0] HIGH_SURR_LO = 16'hd800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hdbff;
  localparam logic [15:0] LOW_SURR_LO  = 16'hdc00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hdfff;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp < 21'h80) begin
      u.n    = 3'd1;
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      u.n    = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.n    = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n    = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

/* design/json_string_unescape_utf8.sv */
// JSON string body unescaper with UTF-8 output, top level.
// Holds the input register, the decoder state, and the result group register.
// Depends on jsu_pkg.
//
//   Channel | Handshake                   | Beat payload
//   in      | in_valid_i / in_stall_o     | data_byte_i, start_req_i
//   out     | out_valid_o / out_stall_i   | out_byte_o, kind_o, last_o
//
// A byte is decoded combinationally while it sits in the input register.
// Its zero to four results leave the group register one per cycle when not stalled,
// so one byte per cycle is kept up unless the output stalls or a byte yields several
// results. A byte that yields no result never waits for the group register.
// Reset clears the valid flags and the decoder state; the block is idle until a start.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_start_q;

  logic [1:0]      phase_q, phase_d;
  logic [1:0]      hex_cnt_q, hex_cnt_d;
  logic [11:0]     hex_acc_q, hex_acc_d;
  logic [9:0]      pend_q, pend_d;
  logic            high_q, high_d;
  logic            active_q, active_d;

  logic            grp_valid_q;
  logic [3:0][7:0] grp_b_q;
  logic [2:0]      grp_cnt_q;
  logic [1:0]      grp_kind_q;

  logic [2:0]      res_n;
  logic [3:0][7:0] res_b;
  logic [1:0]      res_kind;

  hex_t            hv;
  utf8_t           enc;
  logic [15:0]     cp16;
  logic [20:0]     cp21;

  logic            out_take;
  logic            grp_free;
  logic            advance;
  logic            in_take;

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    hex_acc_d = hex_acc_q;
    pend_d    = pend_q;
    high_d    = high_q;
    active_d  = active_q;
    res_n     = 3'd0;
    res_b     = '0;
    res_kind  = KIND_DATA;
    hv        = hex_value(in_byte_q);
    cp16      = '0;
    cp21      = '0;
    enc       = '0;

    if (in_start_q) begin
      phase_d   = PH_NORMAL;
      hex_cnt_d = 2'd0;
      hex_acc_d = '0;
      pend_d    = '0;
      high_d    = 1'b0;
      active_d  = 1'b1;
    end

    if (active_d) begin
      if (phase_d == PH_ESCAPE) begin
        if (in_byte_q == CH_LOW_U) begin
          phase_d   = PH_HEX;
          hex_cnt_d = 2'd0;
          hex_acc_d = '0;
        end else if (high_d) begin
          res_n    = 3'd1;
          res_kind = KIND_ERR;
          active_d = 1'b0;
        end else begin
          phase_d = PH_NORMAL;
          res_n   = 3'd1;
          case (in_byte_q)
            CH_QUOTE:  res_b[0] = CH_QUOTE;
            CH_BSLASH: res_b[0] = CH_BSLASH;
            CH_SLASH:  res_b[0] = CH_SLASH;
            CH_LOW_B:  res_b[0] = CODE_BS;
            CH_LOW_F:  res_b[0] = CODE_FF;
            CH_LOW_N:  res_b[0] = CODE_LF;
            CH_LOW_R:  res_b[0] = CODE_CR;
            CH_LOW_T:  res_b[0] = CODE_TAB;
            default: begin
              res_kind = KIND_ERR;
              active_d = 1'b0;
            end
          endcase
        end
      end else if (phase_d == PH_HEX) begin
        if (!hv.ok) begin
          res_n    = 3'd1;
          res_kind = KIND_ERR;
          active_d = 1'b0;
        end else if (hex_cnt_d != 2'd3) begin
          hex_acc_d = {hex_acc_d[7:0], hv.val};
          hex_cnt_d = hex_cnt_d + 2'd1;
        end else begin
          cp16      = {hex_acc_d, hv.val};
          phase_d   = PH_NORMAL;
          hex_cnt_d = 2'd0;
          if (high_d) begin
            if (cp16 >= LOW_SURR_LO && cp16 <= LOW_SURR_HI) begin
              cp21   = {1'b0, pend_d, cp16[9:0]} + SUPP_BASE;
              enc    = utf8_encode(cp21);
              res_n  = enc.n;
              res_b  = enc.b;
              high_d = 1'b0;
              pend_d = '0;
            end else begin
              res_n    = 3'd1;
              res_kind = KIND_ERR;
              active_d = 1'b0;
            end
          end else if (cp16 >= HIGH_SURR_LO && cp16 <= HIGH_SURR_HI) begin
            pend_d = cp16[9:0];
            high_d = 1'b1;
          end else if (cp16 >= LOW_SURR_LO && cp16 <= LOW_SURR_HI) begin
            res_n    = 3'd1;
            res_kind = KIND_ERR;
            active_d = 1'b0;
          end else begin
            cp21  = {5'd0, cp16};
            enc   = utf8_encode(cp21);
            res_n = enc.n;
            res_b = enc.b;
          end
        end
      end else if (high_d) begin
        if (in_byte_q == CH_BSLASH) begin
          phase_d = PH_ESCAPE;
        end else begin
          res_n    = 3'd1;
          res_kind = KIND_ERR;
          active_d = 1'b0;
        end
      end else if (in_byte_q == CH_QUOTE) begin
        res_n    = 3'd1;
        res_kind = KIND_END;
        active_d = 1'b0;
      end else if (in_byte_q == CH_BSLASH) begin
        phase_d = PH_ESCAPE;
      end else if (in_byte_q < CH_SPACE) begin
        res_n    = 3'd1;
        res_kind = KIND_ERR;
        active_d = 1'b0;
      end else begin
        res_n    = 3'd1;
        res_b[0] = in_byte_q;
      end
    end
  end

  assign out_take   = grp_valid_q && !out_stall_i;
  assign grp_free   = !grp_valid_q || (out_take && grp_cnt_q == 3'd1);
  assign advance    = in_valid_q && (res_n == 3'd0 || grp_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = grp_valid_q;
  assign out_byte_o  = grp_b_q[0];
  assign kind_o      = grp_kind_q;
  assign last_o      = (grp_cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_NORMAL;
      hex_cnt_q <= 2'd0;
      hex_acc_q <= '0;
      pend_q    <= '0;
      high_q    <= 1'b0;
      active_q  <= 1'b0;
    end else if (advance) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      hex_acc_q <= hex_acc_d;
      pend_q    <= pend_d;
      high_q    <= high_d;
      active_q  <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      grp_cnt_q   <= 3'd0;
    end else if (advance && res_n != 3'd0) begin
      grp_valid_q <= 1'b1;
      grp_cnt_q   <= res_n;
    end else if (out_take) begin
      grp_valid_q <= (grp_cnt_q != 3'd1);
      grp_cnt_q   <= grp_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_n != 3'd0) begin
      grp_b_q    <= res_b;
      grp_kind_q <= res_kind;
    end else if (out_take) begin
      grp_b_q <= {8'h00, grp_b_q[3:1]};
    end
  end

  a_grp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_cnt_q != 3'd0 && grp_cnt_q <= 3'd4))
    else $error("Result group holds an impossible count.");

  a_ctrl_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> (last_o && out_byte_o == 8'h00))
    else $error("End or error beat is not a single zero beat.");

  a_group_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_n != 3'd0) |=> (grp_valid_q && grp_cnt_q == $past(res_n)))
    else $error("Decoded results did not reach the group register.");

  a_idle_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_n != 3'd0 && res_kind != KIND_DATA) |=> !active_q)
    else $error("Decoder stayed active after an end or error.");

endmodule
